>>> rtl/bm25_document_scorer_top_assert.svh
// Assertion macros shared by the BM25 document scorer RTL.
`ifndef BM25_DOCUMENT_SCORER_TOP_ASSERT_SVH
`define BM25_DOCUMENT_SCORER_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BDS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bds_pkg.sv
// Types and constants shared by the BM25 document scorer modules.
package bds_pkg;

	// Sequencer states: idle, one per arithmetic step of a scored feature, and emit.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REL,
		ST_NORM,
		ST_DEN,
		ST_NUM,
		ST_RATIO,
		ST_WMAG,
		ST_MAG,
		ST_ACC,
		ST_EMIT
	} bds_state_t;

	// Request kinds.
	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_SCORE = 1'b1
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_K1_GAIN        = 2'd0,
		CFG_LENGTH_BLEND   = 2'd1,
		CFG_AVERAGE_LENGTH = 2'd2
	} cfg_reg_t;

	localparam logic [21:0] K1_RESET    = 22'd4915;
	localparam logic [23:0] BLEND_RESET = 24'd12288;
	localparam logic [31:0] AVG_RESET   = 32'd256000;

	localparam logic [12:0] ONE_Q12 = 13'd4096;
	localparam logic [14:0] ONE_Q14 = 15'd16384;

	// Shift-add multiplier sizes.
	localparam int MUL_AW    = 48;
	localparam int MUL_BW    = 27;
	localparam int MUL_PW    = MUL_AW + MUL_BW;
	localparam int MUL_CNT_W = 5;

	// Multiplier bits consumed by each product.
	localparam logic [MUL_CNT_W-1:0] STEPS_BREL = 5'd24;
	localparam logic [MUL_CNT_W-1:0] STEPS_KN   = 5'd22;
	localparam logic [MUL_CNT_W-1:0] STEPS_NUM  = 5'd16;
	localparam logic [MUL_CNT_W-1:0] STEPS_WI   = 5'd24;
	localparam logic [MUL_CNT_W-1:0] STEPS_AR   = 5'd27;

	// Restoring divider sizes.
	localparam int DIV_NW    = 55;
	localparam int DIV_DW    = 45;
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd55;

	// Request to the multiplier.
	typedef struct packed {
		logic                 start;
		logic [MUL_CNT_W-1:0] steps;
	} mul_ctl_t;

	// Status of an arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

>>> rtl/bds_ram.sv
// Generic single-port-write RAM with registered read.
module bds_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/bds_mul_serial.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module bds_mul_serial import bds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mul_ctl_t          ctl,
	input  logic [MUL_AW-1:0] mcand,
	input  logic [MUL_BW-1:0] mplier,
	output unit_stat_t        stat,
	output logic [MUL_PW-1:0] prod
);

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MUL_AW-1:0]    mcand_q;
	logic [MUL_PW-1:0]    prod_q;
	logic [MUL_AW:0]      upper;
	logic [MUL_AW:0]      partial;

	// Add the multiplicand when the low bit is set, then shift right.
	assign partial = prod_q[0] ? {1'b0, mcand_q} : '0;
	assign upper   = {1'b0, prod_q[MUL_PW-1:MUL_BW]} + partial;

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != 1'b1);
			done_q <= (cnt_q == 1'b1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial product shift register.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q <= mcand;
			prod_q  <= {{MUL_AW{1'b0}}, mplier};
		end else if (busy_q) begin
			prod_q <= {upper, prod_q[MUL_BW-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = prod_q;

endmodule

>>> rtl/bds_div_serial.sv
// Restoring divider, one quotient bit per cycle.
module bds_div_serial import bds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output unit_stat_t        stat,
	output logic [DIV_NW-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DW-1:0]    dsr_q;
	logic [DIV_DW-1:0]    rem_q;
	logic [DIV_NW-1:0]    quo_q;
	logic [DIV_DW:0]      rem_sh;
	logic [DIV_DW:0]      rem_sub;
	logic                 q_bit;

	// Bring down the next dividend bit and try a subtraction.
	assign rem_sh  = {rem_q, quo_q[DIV_NW-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign q_bit   = (rem_sh >= {1'b0, dsr_q});

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_STEPS;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != 1'b1);
			done_q <= (cnt_q == 1'b1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= q_bit ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], q_bit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

>>> rtl/bm25_document_scorer_top.sv
// BM25 document scorer: feature table, sequencer and shared serial arithmetic.
// Load requests leave the sequencer idle and may follow each other back to back.
// A scored feature is accumulated after two serial divisions and five serial products,
// and no new request is taken until the sequencer has returned to idle.
// A score request with zero frequency or an absent slot skips the arithmetic and goes to emit.
// Reset clears the sum, the sequencer and the output valid flag and restores the configuration; the table stays unset.
`include "bm25_document_scorer_top_assert.svh"
module bm25_document_scorer_top import bds_pkg::*; #(
	parameter int MAX_FEATURES = 16,
	parameter int FREQ_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [3:0]         feature_slot,
	input  logic signed [23:0] feature_weight,
	input  logic [23:0]        inverse_doc_freq,
	input  logic [15:0]        term_freq,
	input  logic [23:0]        doc_length,
	input  logic               last_term,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] doc_score,
	output logic               saturated
);

	localparam int SLOT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam logic [15:0] TF_MASK = (FREQ_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << FREQ_BITS) - 32'd1);

	bds_state_t state_q, state_d;
	logic       issued_q;

	logic [21:0] k1_q;
	logic [23:0] blend_q;
	logic [31:0] avg_q;

	logic        in_fire;
	logic        slot_ok;
	logic [15:0] tf_in;
	logic        scored;
	logic        load_we;
	logic        ram_re;
	logic [SLOT_W-1:0] slot_idx;
	logic [47:0] ram_rdata;
	logic [23:0] w_raw;
	logic [23:0] w_mag;
	logic        w_neg;

	logic [15:0] tf_q;
	logic [23:0] doclen_q;
	logic        last_q;
	logic [31:0] rel_q;
	logic [35:0] nrm_q;
	logic [44:0] den_q;
	logic [38:0] num_q;
	logic [26:0] ratio_q;
	logic [47:0] wi_q;
	logic [42:0] mag_q;

	logic signed [47:0] sum_q;
	logic               clip_q;
	logic               out_valid_q;
	logic [47:0]        doc_score_q;
	logic               saturated_q;

	mul_ctl_t          mul_ctl;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	unit_stat_t        mul_stat;
	logic [MUL_PW-1:0] mul_p;
	logic              div_start;
	logic [DIV_NW-1:0] div_n;
	logic [DIV_DW-1:0] div_d;
	unit_stat_t        div_stat;
	logic [DIV_NW-1:0] div_q;

	logic        emit_ok;
	logic        emit_fire;
	logic [31:0] avg_eff;
	logic [24:0] doclen_inc;
	logic [41:0] p14;
	logic [42:0] norm_t;
	logic [42:0] norm_diff;
	logic [35:0] norm_val;
	logic [48:0] sum_ext;
	logic [48:0] mag_ext;
	logic [48:0] acc_sum;
	logic        acc_over;
	logic        acc_under;

	// Request decode.
	assign in_fire  = in_valid && !in_stall;
	assign slot_ok  = (32'(feature_slot) < MAX_FEATURES);
	assign tf_in    = term_freq & TF_MASK;
	assign scored   = (tf_in != 16'd0) && slot_ok;
	assign load_we  = in_fire && (kind == KIND_LOAD) && slot_ok;
	assign ram_re   = in_fire && (kind == KIND_SCORE);
	assign slot_idx = SLOT_W'(feature_slot);

	// Feature table: weight in the upper half, idf in the lower half.
	bds_ram #(
		.WIDTH (48),
		.DEPTH (MAX_FEATURES)
	) u_table (
		.clk   (clk),
		.we    (load_we),
		.waddr (slot_idx),
		.wdata ({feature_weight, inverse_doc_freq}),
		.re    (ram_re),
		.raddr (slot_idx),
		.rdata (ram_rdata)
	);

	assign w_raw = ram_rdata[47:24];
	assign w_neg = w_raw[23];
	assign w_mag = w_neg ? (~w_raw + 24'd1) : w_raw;

	// Shared arithmetic units.
	bds_mul_serial u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.mcand  (mul_a),
		.mplier (mul_b),
		.stat   (mul_stat),
		.prod   (mul_p)
	);

	bds_div_serial u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.stat     (div_stat),
		.quotient (div_q)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q    <= K1_RESET;
			blend_q <= BLEND_RESET;
			avg_q   <= AVG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_K1_GAIN:        k1_q    <= cfg_data[21:0];
				CFG_LENGTH_BLEND:   blend_q <= cfg_data[23:0];
				CFG_AVERAGE_LENGTH: avg_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign emit_ok   = !out_valid_q || !out_stall;
	assign emit_fire = (state_q == ST_EMIT) && last_q && emit_ok;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (kind == KIND_SCORE)) begin
					state_d = scored ? ST_REL : ST_EMIT;
				end
			end
			ST_REL:   if (div_stat.done) state_d = ST_NORM;
			ST_NORM:  if (mul_stat.done) state_d = ST_DEN;
			ST_DEN:   if (mul_stat.done) state_d = ST_NUM;
			ST_NUM:   if (mul_stat.done) state_d = ST_RATIO;
			ST_RATIO: if (div_stat.done) state_d = ST_WMAG;
			ST_WMAG:  if (mul_stat.done) state_d = ST_MAG;
			ST_MAG:   if (mul_stat.done) state_d = ST_ACC;
			ST_ACC:   state_d = ST_EMIT;
			ST_EMIT:  if (!last_q || emit_ok) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign avg_eff    = (avg_q == 32'd0) ? 32'd1 : avg_q;
	assign doclen_inc = {1'b0, doclen_q} + 25'd1;

	// Unit requests and operand selection.
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		mul_ctl.start = 1'b0;
		mul_ctl.steps = STEPS_AR;
		mul_a         = '0;
		mul_b         = '0;
		div_start     = 1'b0;
		div_n         = '0;
		div_d         = '0;
		unique case (state_q)
			ST_REL: begin
				div_start = !issued_q;
				div_n     = {8'd0, doclen_inc, 22'd0};
				div_d     = {13'd0, avg_eff};
			end
			ST_NORM: begin
				mul_ctl.start = !issued_q;
				mul_ctl.steps = STEPS_BREL;
				mul_a         = {16'd0, rel_q};
				mul_b         = {3'd0, blend_q};
			end
			ST_DEN: begin
				mul_ctl.start = !issued_q;
				mul_ctl.steps = STEPS_KN;
				mul_a         = {12'd0, nrm_q};
				mul_b         = {5'd0, k1_q};
			end
			ST_NUM: begin
				mul_ctl.start = !issued_q;
				mul_ctl.steps = STEPS_NUM;
				mul_a         = 48'(k1_q) + 48'(ONE_Q12);
				mul_b         = {11'd0, tf_q};
			end
			ST_RATIO: begin
				div_start = !issued_q;
				div_n     = {num_q, 16'd0};
				div_d     = den_q;
			end
			ST_WMAG: begin
				mul_ctl.start = !issued_q;
				mul_ctl.steps = STEPS_WI;
				mul_a         = {24'd0, ram_rdata[23:0]};
				mul_b         = {3'd0, w_mag};
			end
			ST_MAG: begin
				mul_ctl.start = !issued_q;
				mul_ctl.steps = STEPS_AR;
				mul_a         = wi_q;
				mul_b         = ratio_q;
			end
			default: ;
		endcase
	end

	// Sequencer registers; a unit is started once per state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_stat.done || div_stat.done) begin
				issued_q <= 1'b0;
			end else if (mul_ctl.start || div_start) begin
				issued_q <= 1'b1;
			end
		end
	end

	// Length normalization: one minus b plus b times relative length, clamped.
	assign p14       = mul_p[58:17];
	assign norm_t    = {1'b0, p14} + 43'(ONE_Q14);
	assign norm_diff = norm_t - 43'(blend_q);
	always_comb begin
		if (norm_t < 43'(blend_q)) begin
			norm_val = '0;
		end else if (|norm_diff[42:36]) begin
			norm_val = '1;
		end else begin
			norm_val = norm_diff[35:0];
		end
	end

	// Request fields captured on acceptance; intermediate results captured as each unit finishes.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			tf_q     <= tf_in;
			doclen_q <= doc_length;
			last_q   <= last_term;
		end
		unique case (state_q)
			ST_REL:   if (div_stat.done) rel_q <= (|div_q[54:32]) ? '1 : div_q[31:0];
			ST_NORM:  if (mul_stat.done) nrm_q <= norm_val;
			ST_DEN:   if (mul_stat.done) den_q <= 45'({tf_q, 12'd0}) + 45'(mul_p[62:19]);
			ST_NUM:   if (mul_stat.done) num_q <= mul_p[49:11];
			ST_RATIO: if (div_stat.done) ratio_q <= div_q[26:0];
			ST_WMAG:  if (mul_stat.done) wi_q <= mul_p[50:3];
			ST_MAG:   if (mul_stat.done) mag_q <= mul_p[74:32];
			default: ;
		endcase
	end

	// Signed accumulation with overflow detection on the 49-bit sum.
	assign sum_ext   = {sum_q[47], sum_q};
	assign mag_ext   = {6'd0, mag_q};
	assign acc_sum   = w_neg ? (sum_ext - mag_ext) : (sum_ext + mag_ext);
	assign acc_over  = (acc_sum[48:47] == 2'b01);
	assign acc_under = (acc_sum[48:47] == 2'b10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else if (state_q == ST_ACC) begin
			priority if (acc_over) begin
				sum_q  <= 48'sh7FFF_FFFF_FFFF;
				clip_q <= 1'b1;
			end else if (acc_under) begin
				sum_q  <= 48'sh8000_0000_0000;
				clip_q <= 1'b1;
			end else begin
				sum_q <= acc_sum[47:0];
			end
		end else if (emit_fire) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end
	end

	// Output register; a waiting result holds back only the next emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			doc_score_q <= sum_q;
			saturated_q <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign doc_score = doc_score_q;
	assign saturated = saturated_q;

	// The two arithmetic units never run at the same time.
	`BDS_ASSERT_IMPL(a_units_exclusive, mul_stat.busy, !div_stat.busy, "units overlap")
	// A multiplier result only arrives in a state that expects one.
	`BDS_ASSERT_IMPL(a_mul_done_state, mul_stat.done, (state_q == ST_NORM || state_q == ST_DEN || state_q == ST_NUM || state_q == ST_WMAG || state_q == ST_MAG), "stray product")
	// Emitting a score clears the running sum and its flag.
	`BDS_ASSERT_NEXT(a_sum_cleared, emit_fire, (sum_q == 48'sd0) && !clip_q && out_valid, "sum not cleared")

endmodule
